[rtl/hsv_pkg.sv]
// Shared types and constants for the HSV to RGB converter.
// No dependencies; every other file in rtl/ uses this package.
`default_nettype none

package hsv_pkg;

	localparam int HUE_W = 9;
	localparam int CH_W  = 8;
	localparam int REM_W = 6;

	localparam logic [HUE_W-1:0] HUE_WRAP   = 9'd360;
	localparam logic [REM_W-1:0] SECTOR_DEG = 6'd60;
	localparam logic [CH_W-1:0]  FULL       = 8'd255;

	// numerator and product widths
	localparam int NUM_W = 14;  // 255 * 60 = 15300
	localparam int PA_W  = 16;  // v * (255 - s)
	localparam int X_W   = 22;  // v * (15300 - s * r)
	localparam int PP_W  = 33;
	localparam int QP_W  = 45;

	localparam logic [NUM_W-1:0] FULL_SECTOR = 14'd15300;

	// reciprocal division: floor(x / 255) = (x * P_RECIP) >> P_SHIFT for x <= 65025
	localparam int P_RECIP_W = 17;
	localparam logic [P_RECIP_W-1:0] P_RECIP = 17'd65794;
	localparam int P_SHIFT = 24;

	// floor(x / 15300) = (x * QT_RECIP) >> QT_SHIFT for x <= 255 * 15300
	localparam int QT_RECIP_W = 23;
	localparam logic [QT_RECIP_W-1:0] QT_RECIP = 23'd4491470;
	localparam int QT_SHIFT = 36;

	typedef enum logic [2:0] {
		SEC_RED_YEL = 3'd0,
		SEC_YEL_GRN = 3'd1,
		SEC_GRN_CYN = 3'd2,
		SEC_CYN_BLU = 3'd3,
		SEC_BLU_MAG = 3'd4,
		SEC_MAG_RED = 3'd5
	} sector_t;

	// control that travels down the pipeline with each request
	typedef struct packed {
		logic    valid;
		sector_t sector;
		logic    v_zero;
		logic    s_zero;
	} ctl_t;

endpackage

`default_nettype wire

[rtl/hsv_prep.sv]
// Stage 1: hue wrap and split into sector and remainder.
// Depends on hsv_pkg.
`default_nettype none

module hsv_prep (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [hsv_pkg::HUE_W-1:0]     hue_deg,
	input  wire logic [hsv_pkg::CH_W-1:0]      saturation,
	input  wire logic [hsv_pkg::CH_W-1:0]      brightness,
	output hsv_pkg::ctl_t                      ctl_s1,
	output logic      [hsv_pkg::REM_W-1:0]     rem_s1,
	output logic      [hsv_pkg::CH_W-1:0]      sat_s1,
	output logic      [hsv_pkg::CH_W-1:0]      val_s1
);

	logic [hsv_pkg::HUE_W-1:0] hue_w;
	logic [hsv_pkg::HUE_W-1:0] base;
	logic [hsv_pkg::HUE_W-1:0] diff;
	hsv_pkg::sector_t          sector;

	always_comb begin
		hue_w = (hue_deg >= hsv_pkg::HUE_WRAP) ? hue_deg - hsv_pkg::HUE_WRAP : hue_deg;
		priority if (hue_w >= 9'd300) begin
			sector = hsv_pkg::SEC_MAG_RED;
			base   = 9'd300;
		end else if (hue_w >= 9'd240) begin
			sector = hsv_pkg::SEC_BLU_MAG;
			base   = 9'd240;
		end else if (hue_w >= 9'd180) begin
			sector = hsv_pkg::SEC_CYN_BLU;
			base   = 9'd180;
		end else if (hue_w >= 9'd120) begin
			sector = hsv_pkg::SEC_GRN_CYN;
			base   = 9'd120;
		end else if (hue_w >= 9'd60) begin
			sector = hsv_pkg::SEC_YEL_GRN;
			base   = 9'd60;
		end else begin
			sector = hsv_pkg::SEC_RED_YEL;
			base   = 9'd0;
		end
		diff = hue_w - base;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1.valid  <= start;
			ctl_s1.sector <= sector;
			ctl_s1.v_zero <= (brightness == '0);
			ctl_s1.s_zero <= (saturation == '0);
		end
	end

	always_ff @(posedge clk) begin
		rem_s1 <= diff[hsv_pkg::REM_W-1:0];
		sat_s1 <= saturation;
		val_s1 <= brightness;
	end

endmodule

`default_nettype wire

[rtl/hsv_terms.sv]
// Stages 2 to 4: p, q and t terms by multiplication and reciprocal division.
// Depends on hsv_pkg.
`default_nettype none

module hsv_terms (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire hsv_pkg::ctl_t                 ctl_s1,
	input  wire logic [hsv_pkg::REM_W-1:0]     rem_s1,
	input  wire logic [hsv_pkg::CH_W-1:0]      sat_s1,
	input  wire logic [hsv_pkg::CH_W-1:0]      val_s1,
	output hsv_pkg::ctl_t                      ctl_s4,
	output logic      [hsv_pkg::CH_W-1:0]      val_s4,
	output logic      [hsv_pkg::CH_W-1:0]      p_term,
	output logic      [hsv_pkg::CH_W-1:0]      q_term,
	output logic      [hsv_pkg::CH_W-1:0]      t_term
);

	hsv_pkg::ctl_t ctl_s2, ctl_s3;
	logic [hsv_pkg::CH_W-1:0]  val_s2, val_s3;
	logic [hsv_pkg::REM_W-1:0] rem_c;
	logic [hsv_pkg::NUM_W-1:0] sr_s2, st_s2;
	logic [hsv_pkg::PA_W-1:0]  pa_s2;
	logic [hsv_pkg::NUM_W-1:0] nq, nt;
	logic [hsv_pkg::X_W-1:0]   xq_s3, xt_s3;
	logic [hsv_pkg::PP_W-1:0]  pp_s3;
	logic [hsv_pkg::QP_W-1:0]  yq_s4, yt_s4;
	logic [hsv_pkg::CH_W-1:0]  p_s4;

	always_comb begin
		rem_c = hsv_pkg::SECTOR_DEG - rem_s1;
		nq    = hsv_pkg::FULL_SECTOR - sr_s2;
		nt    = hsv_pkg::FULL_SECTOR - st_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
		end else begin
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
		end
	end

	always_ff @(posedge clk) begin
		// stage 2: scaled remainders and the v(1-s) numerator
		val_s2 <= val_s1;
		sr_s2  <= hsv_pkg::NUM_W'(sat_s1) * hsv_pkg::NUM_W'(rem_s1);
		st_s2  <= hsv_pkg::NUM_W'(sat_s1) * hsv_pkg::NUM_W'(rem_c);
		pa_s2  <= hsv_pkg::PA_W'(val_s1) * hsv_pkg::PA_W'(hsv_pkg::FULL - sat_s1);
		// stage 3: q and t numerators, p reciprocal product
		val_s3 <= val_s2;
		xq_s3  <= hsv_pkg::X_W'(val_s2) * hsv_pkg::X_W'(nq);
		xt_s3  <= hsv_pkg::X_W'(val_s2) * hsv_pkg::X_W'(nt);
		pp_s3  <= hsv_pkg::PP_W'(pa_s2) * hsv_pkg::PP_W'(hsv_pkg::P_RECIP);
		// stage 4: q and t reciprocal products, p term from its product
		val_s4 <= val_s3;
		yq_s4  <= hsv_pkg::QP_W'(xq_s3) * hsv_pkg::QP_W'(hsv_pkg::QT_RECIP);
		yt_s4  <= hsv_pkg::QP_W'(xt_s3) * hsv_pkg::QP_W'(hsv_pkg::QT_RECIP);
		p_s4   <= pp_s3[hsv_pkg::P_SHIFT +: hsv_pkg::CH_W];
	end

	assign p_term = p_s4;
	assign q_term = yq_s4[hsv_pkg::QT_SHIFT +: hsv_pkg::CH_W];
	assign t_term = yt_s4[hsv_pkg::QT_SHIFT +: hsv_pkg::CH_W];

endmodule

`default_nettype wire

[rtl/hsv_to_rgb_converter.sv]
// Top level of the HSV to RGB converter: five-stage pipeline, one pixel per clock.
// Depends on hsv_pkg, hsv_prep and hsv_terms.
//
//   channel   ports                               direction  timing
//   request   start, hue_deg, saturation,         in         taken when start & !busy
//             brightness
//   result    done, red, green, blue              out        one-cycle strobe on done
//
// A request taken with start passes through stage 1, stages 2 to 4 and the output
// register before its result shows with done high; a new request is taken every cycle.
// Stages 2 to 4 hold the multipliers, and each registers the products it forms.
// busy stays low; the pipeline never stalls since results cannot be held off.
// Reset clears the valid bits of every stage, so no result appears from stale data.
`default_nettype none

module hsv_to_rgb_converter (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	output logic                           busy,
	input  wire logic [hsv_pkg::HUE_W-1:0] hue_deg,
	input  wire logic [hsv_pkg::CH_W-1:0]  saturation,
	input  wire logic [hsv_pkg::CH_W-1:0]  brightness,
	output logic                           done,
	output logic      [hsv_pkg::CH_W-1:0]  red,
	output logic      [hsv_pkg::CH_W-1:0]  green,
	output logic      [hsv_pkg::CH_W-1:0]  blue
);

	hsv_pkg::ctl_t            ctl_s1, ctl_s4;
	logic [hsv_pkg::REM_W-1:0] rem_s1;
	logic [hsv_pkg::CH_W-1:0]  sat_s1, val_s1, val_s4;
	logic [hsv_pkg::CH_W-1:0]  p_term, q_term, t_term;
	logic [hsv_pkg::CH_W-1:0]  r_d, g_d, b_d;

	// the pipeline takes a request every cycle
	assign busy = 1'b0;

	// stage 1: wrap the hue, find its sector and remainder
	hsv_prep u_prep (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.hue_deg    (hue_deg),
		.saturation (saturation),
		.brightness (brightness),
		.ctl_s1     (ctl_s1),
		.rem_s1     (rem_s1),
		.sat_s1     (sat_s1),
		.val_s1     (val_s1)
	);

	// stages 2 to 4: form p, q and t
	hsv_terms u_terms (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl_s1 (ctl_s1),
		.rem_s1 (rem_s1),
		.sat_s1 (sat_s1),
		.val_s1 (val_s1),
		.ctl_s4 (ctl_s4),
		.val_s4 (val_s4),
		.p_term (p_term),
		.q_term (q_term),
		.t_term (t_term)
	);

	// stage 5: route V, p, q and t to the channels by sector, or give black or grey
	always_comb begin
		if (ctl_s4.v_zero) begin
			// black
			r_d = '0;
			g_d = '0;
			b_d = '0;
		end else if (ctl_s4.s_zero) begin
			// grey
			r_d = val_s4;
			g_d = val_s4;
			b_d = val_s4;
		end else begin
			unique case (ctl_s4.sector)
				hsv_pkg::SEC_RED_YEL: begin
					r_d = val_s4; g_d = t_term; b_d = p_term;
				end
				hsv_pkg::SEC_YEL_GRN: begin
					r_d = q_term; g_d = val_s4; b_d = p_term;
				end
				hsv_pkg::SEC_GRN_CYN: begin
					r_d = p_term; g_d = val_s4; b_d = t_term;
				end
				hsv_pkg::SEC_CYN_BLU: begin
					r_d = p_term; g_d = q_term; b_d = val_s4;
				end
				hsv_pkg::SEC_BLU_MAG: begin
					r_d = t_term; g_d = p_term; b_d = val_s4;
				end
				default: begin
					r_d = val_s4; g_d = p_term; b_d = q_term;
				end
			endcase
		end
	end

	// hold the strobe for one cycle per result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= ctl_s4.valid;
		end
	end

	always_ff @(posedge clk) begin
		red   <= r_d;
		green <= g_d;
		blue  <= b_d;
	end

`ifndef NO_ASSERTIONS
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##5 done)
		else $error("request did not produce a result after five cycles");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 5))
		else $error("result without a matching request");

	a_black: assert property (@(posedge clk) disable iff (!arst_n)
		(done && ($past(brightness, 5) == '0)) |-> (red == '0 && green == '0 && blue == '0))
		else $error("zero value did not give black");

	a_grey: assert property (@(posedge clk) disable iff (!arst_n)
		(done && ($past(saturation, 5) == '0)) |-> (red == green && green == blue))
		else $error("zero saturation did not give grey");

	a_max_is_value: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (red == $past(brightness, 5) || green == $past(brightness, 5) ||
			blue == $past(brightness, 5)))
		else $error("no channel carries the value term");
`endif

endmodule

`default_nettype wire
